[design/assert_macros.svh]
// assertion macros shared by the register file rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define VCRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent checked in the same cycle as the antecedent
`define VCRF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/vcrf_pkg.sv]
// constants for the video chip register file: commands, register map, read fill bits
`default_nettype none

package vcrf_pkg;

  localparam int SPRITE_COUNT = 8;
  localparam int SPR_IDX_W    = $clog2(SPRITE_COUNT);
  localparam int COLOR_COUNT  = 15;
  localparam int COLOR_IDX_W  = $clog2(COLOR_COUNT);

  // bus commands; any other code makes no bus access
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;

  // register map
  localparam logic [5:0] ADDR_XHIGH     = 6'h10;
  localparam logic [5:0] ADDR_CTRL1     = 6'h11;
  localparam logic [5:0] ADDR_RASTER    = 6'h12;
  localparam logic [5:0] ADDR_PEN_X     = 6'h13;
  localparam logic [5:0] ADDR_PEN_Y     = 6'h14;
  localparam logic [5:0] ADDR_SPR_EN    = 6'h15;
  localparam logic [5:0] ADDR_CTRL2     = 6'h16;
  localparam logic [5:0] ADDR_SPR_YEXP  = 6'h17;
  localparam logic [5:0] ADDR_MEM_PTR   = 6'h18;
  localparam logic [5:0] ADDR_IRQ_REQ   = 6'h19;
  localparam logic [5:0] ADDR_IRQ_MASK  = 6'h1A;
  localparam logic [5:0] ADDR_SPR_PRIO  = 6'h1B;
  localparam logic [5:0] ADDR_SPR_MC    = 6'h1C;
  localparam logic [5:0] ADDR_SPR_XEXP  = 6'h1D;
  localparam logic [5:0] ADDR_SS_HITS   = 6'h1E;
  localparam logic [5:0] ADDR_SB_HITS   = 6'h1F;
  localparam logic [1:0] ADDR_COLOR_HI  = 2'b10;
  localparam logic [3:0] ADDR_COLOR_GAP = 4'hF;

  // bits forced on when read
  localparam logic [7:0] FILL_CTRL2   = 8'hC0;
  localparam logic [7:0] FILL_MEM_PTR = 8'h01;
  localparam logic [2:0] FILL_IRQ_REQ = 3'b111;
  localparam logic [3:0] FILL_NIBBLE  = 4'hF;
  localparam logic [7:0] READ_UNUSED  = 8'hFF;

endpackage

`default_nettype wire

[design/video_chip_register_file.sv]
// top level of the video chip register file: bus access, event latches, read mux
`default_nettype none

//  channel   ports                                   transfer
//  --------  --------------------------------------  --------------------------------
//  command   start, busy, in_cmd .. in_irq_events    start high and busy low at clk
//  result    out_valid, out_rdata, out_irq_pending   out_valid high, one cycle only
//
// one command is taken every cycle while busy is low; its result shows on the cycle after the transfer
// state is updated at the same edge the command is taken, so back-to-back accesses
// see each other's writes with no gap
// rst_n is synchronous; busy is high while rst_n is low and low otherwise
// the receiver cannot stall, so out_valid is a one-cycle strobe per command

module video_chip_register_file (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_cmd,
  input  wire logic [5:0] in_addr,
  input  wire logic [7:0] in_wdata,
  input  wire logic [8:0] in_raster_line,
  input  wire logic [7:0] in_pen_x,
  input  wire logic [7:0] in_pen_y,
  input  wire logic [7:0] in_sprite_hit_events,
  input  wire logic [7:0] in_backdrop_hit_events,
  input  wire logic [3:0] in_irq_events,
  output logic            out_valid,
  output logic [7:0]      out_rdata,
  output logic            out_irq_pending
);

  import vcrf_pkg::*;

  `include "assert_macros.svh"

  // stored registers
  logic [8:0] xpos_r   [SPRITE_COUNT];
  logic [8:0] xpos_nxt [SPRITE_COUNT];
  logic [7:0] ypos_r   [SPRITE_COUNT];
  logic [7:0] ypos_nxt [SPRITE_COUNT];
  logic [3:0] color_r  [COLOR_COUNT];
  logic [3:0] color_nxt[COLOR_COUNT];

  logic [7:0] ctrl1_r, ctrl1_nxt;
  logic [7:0] ctrl2_r, ctrl2_nxt;
  logic [7:0] raster_cmp_r, raster_cmp_nxt;
  logic [7:0] spr_en_r, spr_en_nxt;
  logic [7:0] spr_yexp_r, spr_yexp_nxt;
  logic [7:0] spr_xexp_r, spr_xexp_nxt;
  logic [7:0] spr_prio_r, spr_prio_nxt;
  logic [7:0] spr_mc_r, spr_mc_nxt;
  logic [7:0] mem_ptr_r, mem_ptr_nxt;
  logic [3:0] irq_req_r, irq_req_nxt;
  logic [3:0] irq_mask_r, irq_mask_nxt;
  logic [7:0] ss_hits_r, ss_hits_nxt;
  logic [7:0] sb_hits_r, sb_hits_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] out_rdata_r, out_rdata_nxt;
  logic       out_irq_r, out_irq_nxt;

  logic                   accept;
  logic                   is_read;
  logic                   is_write;
  logic                   is_sprite_addr;
  logic                   is_color_addr;
  logic [SPR_IDX_W-1:0]   spr_idx;
  logic [COLOR_IDX_W-1:0] color_idx;
  logic [7:0]             xhigh_bits;

  // no wait states: the only time a command is refused is during reset
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  assign is_read        = accept & (in_cmd == CMD_READ);
  assign is_write       = accept & (in_cmd == CMD_WRITE);
  // sprite positions sit at the bottom 16 addresses, x/y interleaved
  assign is_sprite_addr = (in_addr[5:4] == 2'b00);
  assign spr_idx        = in_addr[SPR_IDX_W:1];
  // colors fill 0x20..0x2e, the last slot of that row is unused
  assign is_color_addr  = (in_addr[5:4] == ADDR_COLOR_HI) && (in_addr[3:0] != ADDR_COLOR_GAP);
  assign color_idx      = in_addr[COLOR_IDX_W-1:0];

  // ninth x bit of every sprite gathered into one byte
  always_comb begin
    for (int i = 0; i < SPRITE_COUNT; i++) begin
      xhigh_bits[i] = xpos_r[i][8];
    end
  end

  // read mux, sees the state before this command's write and events
  always_comb begin
    out_rdata_nxt = '0;
    if (is_read) begin
      if (is_sprite_addr) begin
        out_rdata_nxt = in_addr[0] ? ypos_r[spr_idx] : xpos_r[spr_idx][7:0];
      end else if (is_color_addr) begin
        out_rdata_nxt = {FILL_NIBBLE, color_r[color_idx]};
      end else begin
        case (in_addr)
          ADDR_XHIGH:    out_rdata_nxt = xhigh_bits;
          ADDR_CTRL1:    out_rdata_nxt = {in_raster_line[8], ctrl1_r[6:0]};
          ADDR_RASTER:   out_rdata_nxt = in_raster_line[7:0];
          ADDR_PEN_X:    out_rdata_nxt = in_pen_x;
          ADDR_PEN_Y:    out_rdata_nxt = in_pen_y;
          ADDR_SPR_EN:   out_rdata_nxt = spr_en_r;
          ADDR_CTRL2:    out_rdata_nxt = ctrl2_r | FILL_CTRL2;
          ADDR_SPR_YEXP: out_rdata_nxt = spr_yexp_r;
          ADDR_MEM_PTR:  out_rdata_nxt = mem_ptr_r | FILL_MEM_PTR;
          ADDR_IRQ_REQ:  out_rdata_nxt = {|(irq_req_r & irq_mask_r), FILL_IRQ_REQ, irq_req_r};
          ADDR_IRQ_MASK: out_rdata_nxt = {FILL_NIBBLE, irq_mask_r};
          ADDR_SPR_PRIO: out_rdata_nxt = spr_prio_r;
          ADDR_SPR_MC:   out_rdata_nxt = spr_mc_r;
          ADDR_SPR_XEXP: out_rdata_nxt = spr_xexp_r;
          ADDR_SS_HITS:  out_rdata_nxt = ss_hits_r;
          ADDR_SB_HITS:  out_rdata_nxt = sb_hits_r;
          default:       out_rdata_nxt = READ_UNUSED;
        endcase
      end
    end
  end

  // write decode and clear-on-read, then events merged on top
  always_comb begin
    xpos_nxt       = xpos_r;
    ypos_nxt       = ypos_r;
    color_nxt      = color_r;
    ctrl1_nxt      = ctrl1_r;
    ctrl2_nxt      = ctrl2_r;
    raster_cmp_nxt = raster_cmp_r;
    spr_en_nxt     = spr_en_r;
    spr_yexp_nxt   = spr_yexp_r;
    spr_xexp_nxt   = spr_xexp_r;
    spr_prio_nxt   = spr_prio_r;
    spr_mc_nxt     = spr_mc_r;
    mem_ptr_nxt    = mem_ptr_r;
    irq_req_nxt    = irq_req_r;
    irq_mask_nxt   = irq_mask_r;
    ss_hits_nxt    = ss_hits_r;
    sb_hits_nxt    = sb_hits_r;

    if (is_write) begin
      if (is_sprite_addr) begin
        if (in_addr[0]) begin
          ypos_nxt[spr_idx] = in_wdata;
        end else begin
          xpos_nxt[spr_idx][7:0] = in_wdata;
        end
      end else if (is_color_addr) begin
        color_nxt[color_idx] = in_wdata[3:0];
      end else begin
        case (in_addr)
          ADDR_XHIGH: begin
            for (int i = 0; i < SPRITE_COUNT; i++) begin
              xpos_nxt[i][8] = in_wdata[i];
            end
          end
          ADDR_CTRL1:    ctrl1_nxt      = in_wdata;
          ADDR_RASTER:   raster_cmp_nxt = in_wdata;
          ADDR_SPR_EN:   spr_en_nxt     = in_wdata;
          ADDR_CTRL2:    ctrl2_nxt      = in_wdata;
          ADDR_SPR_YEXP: spr_yexp_nxt   = in_wdata;
          ADDR_MEM_PTR:  mem_ptr_nxt    = in_wdata;
          // write-one-to-clear
          ADDR_IRQ_REQ:  irq_req_nxt    = irq_req_r & ~in_wdata[3:0];
          ADDR_IRQ_MASK: irq_mask_nxt   = in_wdata[3:0];
          ADDR_SPR_PRIO: spr_prio_nxt   = in_wdata;
          ADDR_SPR_MC:   spr_mc_nxt     = in_wdata;
          ADDR_SPR_XEXP: spr_xexp_nxt   = in_wdata;
          default:       ;
        endcase
      end
    end

    // collision latches clear on read
    if (is_read && (in_addr == ADDR_SS_HITS)) begin
      ss_hits_nxt = '0;
    end
    if (is_read && (in_addr == ADDR_SB_HITS)) begin
      sb_hits_nxt = '0;
    end

    // events land after the access
    if (accept) begin
      ss_hits_nxt = ss_hits_nxt | in_sprite_hit_events;
      sb_hits_nxt = sb_hits_nxt | in_backdrop_hit_events;
      irq_req_nxt = irq_req_nxt | in_irq_events;
    end
  end

  // pending flag from the state as it stands after this command
  assign out_irq_nxt = |(irq_req_nxt & irq_mask_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SPRITE_COUNT; i++) begin
        xpos_r[i] <= '0;
        ypos_r[i] <= '0;
      end
      for (int i = 0; i < COLOR_COUNT; i++) begin
        color_r[i] <= '0;
      end
      ctrl1_r      <= '0;
      ctrl2_r      <= '0;
      raster_cmp_r <= '0;
      spr_en_r     <= '0;
      spr_yexp_r   <= '0;
      spr_xexp_r   <= '0;
      spr_prio_r   <= '0;
      spr_mc_r     <= '0;
      mem_ptr_r    <= '0;
      irq_req_r    <= '0;
      irq_mask_r   <= '0;
      ss_hits_r    <= '0;
      sb_hits_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      xpos_r       <= xpos_nxt;
      ypos_r       <= ypos_nxt;
      color_r      <= color_nxt;
      ctrl1_r      <= ctrl1_nxt;
      ctrl2_r      <= ctrl2_nxt;
      raster_cmp_r <= raster_cmp_nxt;
      spr_en_r     <= spr_en_nxt;
      spr_yexp_r   <= spr_yexp_nxt;
      spr_xexp_r   <= spr_xexp_nxt;
      spr_prio_r   <= spr_prio_nxt;
      spr_mc_r     <= spr_mc_nxt;
      mem_ptr_r    <= mem_ptr_nxt;
      irq_req_r    <= irq_req_nxt;
      irq_mask_r   <= irq_mask_nxt;
      ss_hits_r    <= ss_hits_nxt;
      sb_hits_r    <= sb_hits_nxt;
      out_valid_r  <= accept;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rdata_r <= out_rdata_nxt;
      out_irq_r   <= out_irq_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rdata       = out_rdata_r;
  assign out_irq_pending = out_irq_r;

  // every transfer gives exactly one strobe on the next cycle
  `VCRF_ASSERT_NEXT(a_strobe_follows, clk, rst_n, accept, out_valid_r, "missing result strobe")
  `VCRF_ASSERT_NEXT(a_no_extra_strobe, clk, rst_n, !accept, !out_valid_r, "result without transfer")
  // non-read commands return zero data
  `VCRF_ASSERT_NEXT(a_rdata_zero, clk, rst_n, accept && (in_cmd != CMD_READ),
                    out_rdata_r == '0, "nonzero data on non-read")
  // a collision read leaves only the same cycle's events in the latch
  `VCRF_ASSERT_NEXT(a_hit_clear, clk, rst_n, is_read && (in_addr == ADDR_SS_HITS),
                    ss_hits_r == $past(in_sprite_hit_events), "collision latch not cleared")
  // reported pending flag matches the stored request and mask
  `VCRF_ASSERT_SAME(a_irq_match, clk, rst_n, out_valid_r,
                    out_irq_r == (|(irq_req_r & irq_mask_r)), "pending flag mismatch")

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the video chip register file: directed and random bus traffic
`timescale 1ns / 1ps

module tb_top;
  import vcrf_pkg::*;

  // codes and addresses the package does not name
  localparam logic [1:0] CMD_IDLE     = 2'd2;
  localparam logic [1:0] CMD_SPARE    = 2'd3;
  localparam logic [5:0] ADDR_SPR0_X  = 6'h00;
  localparam logic [5:0] ADDR_SPR0_Y  = 6'h01;
  localparam logic [5:0] ADDR_SPR7_X  = 6'h0E;
  localparam logic [5:0] ADDR_SPR7_Y  = 6'h0F;
  localparam logic [5:0] ADDR_COLOR_0 = 6'h20;
  localparam logic [5:0] ADDR_COLOR_E = 6'h2E;
  localparam logic [5:0] ADDR_GAP_LO  = 6'h2F;
  localparam logic [5:0] ADDR_GAP_HI  = 6'h3F;

  localparam int RANDOM_TARGET = 650;
  // limit sits well above the slowest run, even with every gap at its longest
  localparam int CYCLE_LIMIT   = 400000;

  // one bus access together with the live inputs and events of that cycle
  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] addr;
    logic [7:0] wdata;
    logic [8:0] raster_line;
    logic [7:0] pen_x;
    logic [7:0] pen_y;
    logic [7:0] sprite_hits;
    logic [7:0] backdrop_hits;
    logic [3:0] irq_events;
  } bus_access_t;

  // what one access must produce on the result ports
  typedef struct {
    int unsigned seq;
    logic [7:0]  rdata;
    logic        irq_pending;
  } read_result_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_cmd;
  logic [5:0] in_addr;
  logic [7:0] in_wdata;
  logic [8:0] in_raster_line;
  logic [7:0] in_pen_x;
  logic [7:0] in_pen_y;
  logic [7:0] in_sprite_hit_events;
  logic [7:0] in_backdrop_hit_events;
  logic [3:0] in_irq_events;
  logic       out_valid;
  logic [7:0] out_rdata;
  logic       out_irq_pending;

  video_chip_register_file i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_cmd                 (in_cmd),
    .in_addr                (in_addr),
    .in_wdata               (in_wdata),
    .in_raster_line         (in_raster_line),
    .in_pen_x               (in_pen_x),
    .in_pen_y               (in_pen_y),
    .in_sprite_hit_events   (in_sprite_hit_events),
    .in_backdrop_hit_events (in_backdrop_hit_events),
    .in_irq_events          (in_irq_events),
    .out_valid              (out_valid),
    .out_rdata              (out_rdata),
    .out_irq_pending        (out_irq_pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // shadow copy of the register file, updated at each accepted transfer
  logic [8:0] shadow_xpos [SPRITE_COUNT];
  logic [7:0] shadow_ypos [SPRITE_COUNT];
  logic [7:0] shadow_ctrl1;
  logic [7:0] shadow_ctrl2;
  logic [7:0] shadow_raster_cmp;
  logic [7:0] shadow_spr_en;
  logic [7:0] shadow_yexp;
  logic [7:0] shadow_xexp;
  logic [7:0] shadow_prio;
  logic [7:0] shadow_mc;
  logic [7:0] shadow_mem_ptr;
  logic [3:0] shadow_irq_req;
  logic [3:0] shadow_irq_mask;
  logic [7:0] shadow_ss_hits;
  logic [7:0] shadow_sb_hits;
  logic [3:0] shadow_colors [COLOR_COUNT];

  read_result_t results_due[$];
  read_result_t oldest_result;
  int unsigned  accepted_count = 0;
  int unsigned  mismatch_count = 0;
  bit           no_idle_stretch = 1'b0;

  function automatic bit is_color_addr(input logic [5:0] addr);
    return addr[5:4] == ADDR_COLOR_HI && addr[3:0] != ADDR_COLOR_GAP;
  endfunction

  // applies one access to the shadow state and returns the byte read, and the
  // interrupt line as it stands once the events are merged
  task automatic predict_access(input bus_access_t a, output logic [7:0] rd,
                                output logic irq);
    logic [2:0] spr;
    int i;
    rd  = '0;
    spr = a.addr[3:1];
    if (a.cmd == CMD_READ) begin
      if (a.addr < ADDR_XHIGH) begin
        rd = a.addr[0] ? shadow_ypos[spr] : shadow_xpos[spr][7:0];
      end else if (is_color_addr(a.addr)) begin
        rd = {FILL_NIBBLE, shadow_colors[a.addr[3:0]]};
      end else begin
        case (a.addr)
          ADDR_XHIGH: begin
            for (i = 0; i < SPRITE_COUNT; i++) rd[i] = shadow_xpos[i][8];
          end
          ADDR_CTRL1:    rd = {a.raster_line[8], shadow_ctrl1[6:0]};
          ADDR_RASTER:   rd = a.raster_line[7:0];
          ADDR_PEN_X:    rd = a.pen_x;
          ADDR_PEN_Y:    rd = a.pen_y;
          ADDR_SPR_EN:   rd = shadow_spr_en;
          ADDR_CTRL2:    rd = shadow_ctrl2 | FILL_CTRL2;
          ADDR_SPR_YEXP: rd = shadow_yexp;
          ADDR_MEM_PTR:  rd = shadow_mem_ptr | FILL_MEM_PTR;
          ADDR_IRQ_REQ: begin
            rd = {|(shadow_irq_req & shadow_irq_mask), FILL_IRQ_REQ, shadow_irq_req};
          end
          ADDR_IRQ_MASK: rd = {FILL_NIBBLE, shadow_irq_mask};
          ADDR_SPR_PRIO: rd = shadow_prio;
          ADDR_SPR_MC:   rd = shadow_mc;
          ADDR_SPR_XEXP: rd = shadow_xexp;
          ADDR_SS_HITS: begin
            rd = shadow_ss_hits;
            shadow_ss_hits = '0;
          end
          ADDR_SB_HITS: begin
            rd = shadow_sb_hits;
            shadow_sb_hits = '0;
          end
          default:       rd = READ_UNUSED;
        endcase
      end
    end else if (a.cmd == CMD_WRITE) begin
      if (a.addr < ADDR_XHIGH) begin
        if (a.addr[0]) shadow_ypos[spr] = a.wdata;
        else shadow_xpos[spr][7:0] = a.wdata;
      end else if (is_color_addr(a.addr)) begin
        shadow_colors[a.addr[3:0]] = a.wdata[3:0];
      end else begin
        case (a.addr)
          ADDR_XHIGH: begin
            for (i = 0; i < SPRITE_COUNT; i++) shadow_xpos[i][8] = a.wdata[i];
          end
          ADDR_CTRL1:    shadow_ctrl1 = a.wdata;
          ADDR_RASTER:   shadow_raster_cmp = a.wdata;
          ADDR_SPR_EN:   shadow_spr_en = a.wdata;
          ADDR_CTRL2:    shadow_ctrl2 = a.wdata;
          ADDR_SPR_YEXP: shadow_yexp = a.wdata;
          ADDR_MEM_PTR:  shadow_mem_ptr = a.wdata;
          ADDR_IRQ_REQ:  shadow_irq_req = shadow_irq_req & ~a.wdata[3:0];
          ADDR_IRQ_MASK: shadow_irq_mask = a.wdata[3:0];
          ADDR_SPR_PRIO: shadow_prio = a.wdata;
          ADDR_SPR_MC:   shadow_mc = a.wdata;
          ADDR_SPR_XEXP: shadow_xexp = a.wdata;
          default: ;
        endcase
      end
    end
    // events land after the access, so they survive a clearing read
    shadow_ss_hits = shadow_ss_hits | a.sprite_hits;
    shadow_sb_hits = shadow_sb_hits | a.backdrop_hits;
    shadow_irq_req = shadow_irq_req | a.irq_events;
    irq = |(shadow_irq_req & shadow_irq_mask);
  endtask

  // plain bus operation: live inputs random, no events
  function automatic bus_access_t bus_op(input logic [1:0] cmd, input logic [5:0] addr,
                                         input logic [7:0] wdata);
    bus_access_t a;
    a.cmd           = cmd;
    a.addr          = addr;
    a.wdata         = wdata;
    a.raster_line   = 9'($urandom_range(0, 511));
    a.pen_x         = 8'($urandom);
    a.pen_y         = 8'($urandom);
    a.sprite_hits   = '0;
    a.backdrop_hits = '0;
    a.irq_events    = '0;
    return a;
  endfunction

  // events are kept sparse so that the clear-on-read latches do not saturate
  function automatic bus_access_t random_access();
    bus_access_t a;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) a.cmd = CMD_READ;
    else if (pick < 8) a.cmd = CMD_WRITE;
    else a.cmd = $urandom_range(0, 1) ? CMD_IDLE : CMD_SPARE;
    a = bus_op(a.cmd, $urandom_range(0, 9) < 7 ? 6'($urandom_range(0, 46))
                                               : 6'($urandom_range(0, 63)),
               8'($urandom));
    if ($urandom_range(0, 3) == 0) a.sprite_hits = 8'($urandom);
    if ($urandom_range(0, 3) == 0) a.backdrop_hits = 8'($urandom);
    if ($urandom_range(0, 9) < 3) a.irq_events = 4'($urandom_range(1, 15));
    return a;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (no_idle_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic drive_bus(input bus_access_t a);
    in_cmd                 = a.cmd;
    in_addr                = a.addr;
    in_wdata               = a.wdata;
    in_raster_line         = a.raster_line;
    in_pen_x               = a.pen_x;
    in_pen_y               = a.pen_y;
    in_sprite_hit_events   = a.sprite_hits;
    in_backdrop_hit_events = a.backdrop_hits;
    in_irq_events          = a.irq_events;
  endtask

  // one transfer: drive on the falling edge, wait out busy, take the rising edge
  // as the transfer, then maybe drop start for a while with junk on the bus
  task automatic send_access(input bus_access_t a);
    read_result_t r;
    logic [7:0]   rd;
    logic         irq;
    int           gap;
    @(negedge clk);
    drive_bus(a);
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_access(a, rd, irq);
    r.seq         = accepted_count;
    r.rdata       = rd;
    r.irq_pending = irq;
    results_due.push_back(r);
    accepted_count++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      drive_bus(random_access());
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // start may still be high from a transfer with no gap after it
  task automatic release_bus();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_for_drain();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input int unsigned seq,
                               input logic [7:0] expected, input logic [7:0] actual);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s, transfer %0d: expected %02h, got %02h",
               what, seq, expected, actual);
  endtask

  // result checker; sampling at the rising edge sees the values of the cycle
  // that edge closes
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        note_mismatch("unexpected result", accepted_count, '0, out_rdata);
      end else begin
        oldest_result = results_due.pop_front();
        if (out_rdata !== oldest_result.rdata)
          note_mismatch("rdata", oldest_result.seq, oldest_result.rdata, out_rdata);
        if (out_irq_pending !== oldest_result.irq_pending)
          note_mismatch("irq_pending", oldest_result.seq,
                        8'(oldest_result.irq_pending), 8'(out_irq_pending));
      end
    end
  end

  // sprite positions: both ends of the low byte, the ninth X bit, Y extremes
  task automatic test_sprite_positions();
    send_access(bus_op(CMD_WRITE, ADDR_SPR7_X, 8'hFF));
    send_access(bus_op(CMD_WRITE, ADDR_XHIGH, 8'h80));
    send_access(bus_op(CMD_READ, ADDR_SPR7_X, 8'h00));
    send_access(bus_op(CMD_READ, ADDR_XHIGH, 8'h00));
    send_access(bus_op(CMD_WRITE, ADDR_SPR7_Y, 8'hFF));
    send_access(bus_op(CMD_READ, ADDR_SPR7_Y, 8'h00));
    send_access(bus_op(CMD_WRITE, ADDR_SPR0_Y, 8'h00));
    send_access(bus_op(CMD_READ, ADDR_SPR0_X, 8'h00));
  endtask

  // fill bits, live raster and pen reads, read-only and unused addresses, colors
  task automatic test_fixed_registers();
    bus_access_t a;
    send_access(bus_op(CMD_WRITE, ADDR_CTRL1, 8'hFF));
    a = bus_op(CMD_READ, ADDR_CTRL1, 8'h00);
    a.raster_line = 9'h1FF;
    send_access(a);
    a = bus_op(CMD_READ, ADDR_RASTER, 8'h00);
    a.raster_line = 9'h0FF;
    send_access(a);
    send_access(bus_op(CMD_READ, ADDR_CTRL2, 8'h00));
    send_access(bus_op(CMD_READ, ADDR_MEM_PTR, 8'h00));
    // a write to the pen latch must not stick
    send_access(bus_op(CMD_WRITE, ADDR_PEN_X, 8'h5A));
    a = bus_op(CMD_READ, ADDR_PEN_X, 8'h00);
    a.pen_x = 8'hFF;
    send_access(a);
    send_access(bus_op(CMD_WRITE, ADDR_COLOR_E, 8'hFF));
    send_access(bus_op(CMD_READ, ADDR_COLOR_E, 8'h00));
    send_access(bus_op(CMD_READ, ADDR_COLOR_0, 8'h00));
    send_access(bus_op(CMD_WRITE, ADDR_GAP_HI, 8'hFF));
    send_access(bus_op(CMD_READ, ADDR_GAP_LO, 8'h00));
  endtask

  // interrupt request latch, mask and the pending line, write-one-to-clear
  task automatic test_interrupts();
    bus_access_t a;
    send_access(bus_op(CMD_WRITE, ADDR_IRQ_MASK, 8'hFF));
    a = bus_op(CMD_IDLE, ADDR_IRQ_REQ, 8'h00);
    a.irq_events = 4'hF;
    send_access(a);
    send_access(bus_op(CMD_WRITE, ADDR_IRQ_REQ, 8'h05));
    send_access(bus_op(CMD_READ, ADDR_IRQ_REQ, 8'h00));
    send_access(bus_op(CMD_WRITE, ADDR_IRQ_MASK, 8'h00));
  endtask

  // collision latches clear on read, same-cycle events land after the clear
  task automatic test_collisions();
    bus_access_t a;
    a = bus_op(CMD_SPARE, ADDR_SS_HITS, 8'h00);
    a.sprite_hits   = 8'hFF;
    a.backdrop_hits = 8'hFF;
    send_access(a);
    a = bus_op(CMD_READ, ADDR_SS_HITS, 8'h00);
    a.sprite_hits = 8'h01;
    send_access(a);
    send_access(bus_op(CMD_READ, ADDR_SS_HITS, 8'h00));
    send_access(bus_op(CMD_READ, ADDR_SB_HITS, 8'h00));
  endtask

  // every cycle a transfer, so writes are read back on the very next cycle
  task automatic test_back_to_back();
    logic [5:0] addr;
    no_idle_stretch = 1'b1;
    repeat (20) begin
      addr = 6'($urandom_range(0, 63));
      send_access(bus_op(CMD_WRITE, addr, 8'($urandom)));
      send_access(bus_op(CMD_READ, addr, 8'h00));
    end
    no_idle_stretch = 1'b0;
  endtask

  // hold the bus off until every result is back, then resume
  task automatic test_drain_pause();
    repeat (10) send_access(random_access());
    release_bus();
    wait_for_drain();
    repeat (10) send_access(random_access());
  endtask

  // mostly short well-formed sequences with random content, some plain noise
  task automatic test_random_traffic();
    bus_access_t a;
    logic [5:0]  addr;
    int unsigned pick;
    while (accepted_count < RANDOM_TARGET) begin
      pick = $urandom_range(0, 9);
      case (pick)
        4, 5: begin
          addr = 6'($urandom_range(0, 63));
          send_access(bus_op(CMD_WRITE, addr, 8'($urandom)));
          send_access(bus_op(CMD_READ, addr, 8'h00));
        end
        6: begin
          send_access(bus_op(CMD_WRITE, ADDR_IRQ_MASK, 8'($urandom)));
          a = bus_op(CMD_IDLE, 6'($urandom), 8'($urandom));
          a.irq_events = 4'($urandom);
          send_access(a);
          send_access(bus_op(CMD_READ, ADDR_IRQ_REQ, 8'h00));
          send_access(bus_op(CMD_WRITE, ADDR_IRQ_REQ, 8'($urandom)));
        end
        7: begin
          addr = $urandom_range(0, 1) ? ADDR_SS_HITS : ADDR_SB_HITS;
          a = bus_op(CMD_SPARE, 6'($urandom), 8'($urandom));
          a.sprite_hits   = 8'($urandom);
          a.backdrop_hits = 8'($urandom);
          send_access(a);
          a = bus_op(CMD_READ, addr, 8'h00);
          a.sprite_hits   = $urandom_range(0, 1) ? 8'($urandom) : 8'h00;
          a.backdrop_hits = $urandom_range(0, 1) ? 8'($urandom) : 8'h00;
          send_access(a);
          send_access(bus_op(CMD_READ, addr, 8'h00));
        end
        8: begin
          addr = {2'b00, 3'($urandom), 1'b0};
          send_access(bus_op(CMD_WRITE, ADDR_XHIGH, 8'($urandom)));
          send_access(bus_op(CMD_WRITE, addr, 8'($urandom)));
          send_access(bus_op(CMD_READ, addr, 8'h00));
          send_access(bus_op(CMD_READ, ADDR_XHIGH, 8'h00));
        end
        9: begin
          no_idle_stretch = 1'b1;
          repeat (6) send_access(random_access());
          no_idle_stretch = 1'b0;
        end
        default: send_access(random_access());
      endcase
    end
  endtask

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    shadow_xpos       = '{default: '0};
    shadow_ypos       = '{default: '0};
    shadow_colors     = '{default: '0};
    shadow_ctrl1      = '0;
    shadow_ctrl2      = '0;
    shadow_raster_cmp = '0;
    shadow_spr_en     = '0;
    shadow_yexp       = '0;
    shadow_xexp       = '0;
    shadow_prio       = '0;
    shadow_mc         = '0;
    shadow_mem_ptr    = '0;
    shadow_irq_req    = '0;
    shadow_irq_mask   = '0;
    shadow_ss_hits    = '0;
    shadow_sb_hits    = '0;
    start = 1'b0;
    rst_n = 1'b0;
    drive_bus('0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_sprite_positions();
    test_fixed_registers();
    test_interrupts();
    test_collisions();
    test_back_to_back();
    test_drain_pause();
    test_random_traffic();

    release_bus();
    wait_for_drain();
    // idle on to catch a stray strobe
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
